// ----- sv/vn_pkg.sv -----
// shared constants and types for the 4-component vector normalizer
// no dependencies
package vn_pkg;

    localparam int COMP_WIDTH    = 32;
    localparam int OUT_FRAC_BITS = 30;
    localparam int LANES         = 4;
    localparam int IO_W          = 32;
    localparam int MAG_W         = 33;
    localparam int ABS_W         = COMP_WIDTH;
    localparam int SQ_W          = 2 * COMP_WIDTH;
    localparam int SUM_W         = 2 * COMP_WIDTH + 1;
    localparam int ROOT_W        = COMP_WIDTH + 1;
    localparam int REM_W         = 2 * COMP_WIDTH + 2;
    localparam int SQRT_STAGES   = COMP_WIDTH + 1;
    localparam int DIV_STAGES    = OUT_FRAC_BITS + 1;
    localparam int QUO_W         = OUT_FRAC_BITS + 1;
    localparam int DR_W          = COMP_WIDTH + 2;
    localparam int SQ_STAGES     = 4;
    localparam int LATENCY       = SQ_STAGES + SQRT_STAGES + DIV_STAGES + 1;

    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][ABS_W-1:0] abs_val;
    } comps_t;

endpackage

// ----- sv/vn_square.sv -----
// absolute values, squares and sum of squares, four register stages
// depends on vn_pkg
module vn_square (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic [vn_pkg::LANES-1:0][vn_pkg::IO_W-1:0] comp,
    output logic                                      out_valid,
    output vn_pkg::comps_t                            out_comps,
    output logic [vn_pkg::SUM_W-1:0]                  out_sum
);
    import vn_pkg::*;

    logic [3:0]                  vld_reg;
    comps_t                      c1_reg, c2_reg, c3_reg, c4_reg;
    comps_t                      c1_next;
    logic [LANES-1:0][SQ_W-1:0]  sq_reg, sq_next;
    logic [1:0][SQ_W-1:0]        pair_reg, pair_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;

    always_comb
    begin
        logic [COMP_WIDTH-1:0] raw;
        for (int i = 0; i < LANES; i++)
        begin
            raw = comp[i][COMP_WIDTH-1:0];
            c1_next.neg[i]     = raw[COMP_WIDTH-1];
            c1_next.abs_val[i] = raw[COMP_WIDTH-1] ? ABS_W'(~raw + 1'b1) : ABS_W'(raw);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sq_next[i] = SQ_W'(c1_reg.abs_val[i]) * SQ_W'(c1_reg.abs_val[i]);
        end
        pair_next[0] = sq_reg[0] + sq_reg[1];
        pair_next[1] = sq_reg[2] + sq_reg[3];
        sum_next     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg   <= c1_next;
        c2_reg   <= c1_reg;
        c3_reg   <= c2_reg;
        c4_reg   <= c3_reg;
        sq_reg   <= sq_next;
        pair_reg <= pair_next;
        sum_reg  <= sum_next;
    end

    assign out_valid = vld_reg[3];
    assign out_comps = c4_reg;
    assign out_sum   = sum_reg;

endmodule

// ----- sv/vn_sqrt.sv -----
// pipelined floor square root, one root bit per stage
// depends on vn_pkg
module vn_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  vn_pkg::comps_t             in_comps,
    input  logic [vn_pkg::SUM_W-1:0]   in_sum,
    output logic                       out_valid,
    output vn_pkg::comps_t             out_comps,
    output logic [vn_pkg::ROOT_W-1:0]  out_root
);
    import vn_pkg::*;

    logic              vld_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    comps_t            cmp_reg  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        localparam int K = SQRT_STAGES - 1 - s;

        logic              vld_in;
        logic [REM_W-1:0]  rem_in, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        comps_t            cmp_in;

        if (s == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = REM_W'(in_sum);
            assign root_in = '0;
            assign cmp_in  = in_comps;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign cmp_in  = cmp_reg[s-1];
        end

        // trial = (2*root + 2^k) * 2^k with root holding only bits above k
        always_comb
        begin
            trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            cmp_reg[s]  <= cmp_in;
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_comps = cmp_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];

endmodule

// ----- sv/vn_div.sv -----
// four-lane pipelined restoring divider and output register
// depends on vn_pkg
module vn_div (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  vn_pkg::comps_t                            in_comps,
    input  logic [vn_pkg::ROOT_W-1:0]                 in_root,
    output logic                                      out_valid,
    output logic [vn_pkg::LANES-1:0][vn_pkg::IO_W-1:0] out_unit,
    output logic [vn_pkg::MAG_W-1:0]                  out_mag,
    output logic                                      out_zero
);
    import vn_pkg::*;

    logic                         vld_reg  [DIV_STAGES];
    logic [ROOT_W-1:0]            root_reg [DIV_STAGES];
    logic [LANES-1:0]             neg_reg  [DIV_STAGES];
    logic [LANES-1:0][DR_W-1:0]   r_reg    [DIV_STAGES];
    logic [LANES-1:0][QUO_W-1:0]  q_reg    [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        logic                        vld_in;
        logic [ROOT_W-1:0]           root_in;
        logic [LANES-1:0]            neg_in;
        logic [LANES-1:0][DR_W-1:0]  r_in, r_next;
        logic [LANES-1:0][QUO_W-1:0] q_in, q_next;

        if (j == 0)
        begin : g_first
            // component never exceeds the length, so the top bit is a plain compare
            assign vld_in  = in_valid;
            assign root_in = in_root;
            assign neg_in  = in_comps.neg;
            assign q_in    = '0;
            for (genvar i = 0; i < LANES; i++)
            begin : g_ld
                assign r_in[i] = DR_W'(in_comps.abs_val[i]);
            end
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign root_in = root_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign q_in    = q_reg[j-1];
            for (genvar i = 0; i < LANES; i++)
            begin : g_sh
                assign r_in[i] = {r_reg[j-1][i][DR_W-2:0], 1'b0};
            end
        end

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (r_in[i] >= DR_W'(root_in))
                begin
                    r_next[i] = r_in[i] - DR_W'(root_in);
                    q_next[i] = {q_in[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r_next[i] = r_in[i];
                    q_next[i] = {q_in[i][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[j] <= root_in;
            neg_reg[j]  <= neg_in;
            r_reg[j]    <= r_next;
            q_reg[j]    <= q_next;
        end
    end

    logic                         done_reg;
    logic [LANES-1:0][IO_W-1:0]   unit_reg, unit_next;
    logic [MAG_W-1:0]             mag_reg;
    logic                         zero_reg, zero_next;

    always_comb
    begin
        logic [IO_W-1:0] qv;
        zero_next = (root_reg[DIV_STAGES-1] == '0);
        for (int i = 0; i < LANES; i++)
        begin
            qv = IO_W'(q_reg[DIV_STAGES-1][i]);
            if (zero_next)
            begin
                unit_next[i] = '0;
            end
            else if (neg_reg[DIV_STAGES-1][i])
            begin
                unit_next[i] = ~qv + 1'b1;
            end
            else
            begin
                unit_next[i] = qv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        mag_reg  <= MAG_W'(root_reg[DIV_STAGES-1]);
        zero_reg <= zero_next;
    end

    assign out_valid = done_reg;
    assign out_unit  = unit_reg;
    assign out_mag   = mag_reg;
    assign out_zero  = zero_reg;

endmodule

// ----- sv/vector4_normalize_top.sv -----
// Vector normalizer: takes one 4-component Q15.16 vector per clock whenever start is high
// (busy is always low) and, at the end of the pipeline, pulses done for one cycle with the
// Q17.16 length (floor square root of the exact sum of squares) and the four Q1.30 unit
// components truncated toward zero; a zero vector gives zeros and is_zero. The pipeline has
// 4 square/sum stages + 33 square-root stages (one root bit each) + 31 divider stages
// (one quotient bit each) + 1 output register; throughput is one vector per cycle.
// Results cannot be held off, so the consumer must take every done beat.
// depends on vn_pkg, vn_square, vn_sqrt, vn_div
module vector4_normalize_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [vn_pkg::IO_W-1:0]  comp_x,
    input  logic signed [vn_pkg::IO_W-1:0]  comp_y,
    input  logic signed [vn_pkg::IO_W-1:0]  comp_z,
    input  logic signed [vn_pkg::IO_W-1:0]  comp_w,
    output logic                            done,
    output logic signed [vn_pkg::IO_W-1:0]  unit_x,
    output logic signed [vn_pkg::IO_W-1:0]  unit_y,
    output logic signed [vn_pkg::IO_W-1:0]  unit_z,
    output logic signed [vn_pkg::IO_W-1:0]  unit_w,
    output logic [vn_pkg::MAG_W-1:0]        magnitude,
    output logic                            is_zero
);
    import vn_pkg::*;

    logic [LANES-1:0][IO_W-1:0] comp, unit;
    logic                       sq_valid, rt_valid;
    comps_t                     sq_comps, rt_comps;
    logic [SUM_W-1:0]           sq_sum;
    logic [ROOT_W-1:0]          rt_root;

    assign busy    = 1'b0;
    assign comp[0] = comp_x;
    assign comp[1] = comp_y;
    assign comp[2] = comp_z;
    assign comp[3] = comp_w;

    vn_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .comp      (comp),
        .out_valid (sq_valid),
        .out_comps (sq_comps),
        .out_sum   (sq_sum)
    );

    vn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_comps  (sq_comps),
        .in_sum    (sq_sum),
        .out_valid (rt_valid),
        .out_comps (rt_comps),
        .out_root  (rt_root)
    );

    vn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_comps  (rt_comps),
        .in_root   (rt_root),
        .out_valid (done),
        .out_unit  (unit),
        .out_mag   (magnitude),
        .out_zero  (is_zero)
    );

    assign unit_x = unit[0];
    assign unit_y = unit[1];
    assign unit_z = unit[2];
    assign unit_w = unit[3];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done beat without a matching start");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_zero) |-> (magnitude == '0 && unit_x == '0 && unit_y == '0
                               && unit_z == '0 && unit_w == '0))
        else $error("zero vector with nonzero outputs");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_zero) |-> (magnitude != '0))
        else $error("zero length without zero flag");
`endif

endmodule
